### hdl/eec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_pkg
// Shared widths, codes, constants and arithmetic helpers of the elastic
// easing curve evaluator.
// ----------------------------------------------------------------------------
package eec_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int DB         = 24;   // divisor / remainder width
    localparam int XB         = 20;   // envelope exponent width, Q4.16
    localparam int NB         = (24 + ANGLE_BITS > 36) ? 24 + ANGLE_BITS : 36;
    localparam int QB         = (ANGLE_BITS > XB) ? ANGLE_BITS : XB;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [1:0] KIND_NORM = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_DURATION = 3'd1;
    localparam logic [2:0] REG_CHANGE   = 3'd2;
    localparam logic [2:0] REG_AMPL     = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;

    localparam logic [30:0] SIN_C [5] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       wneg;
        logic       second;
    } t_side;

    function automatic logic [33:0] mulq30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'(1) * (64'd1 << 29);
        return p[63:30];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-1/2^n) in Q30
    function automatic logic [63:0] exp_k(input int n);
        logic [63:0] k;
        k = isqrt64(64'd1 << 59);
        for (int j = 1; j < 16; j++) begin
            if (j < n) begin
                k = isqrt64(k << 30);
            end
        end
        return k;
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DB:0] div_step(input logic [DB-1:0] rem, input logic nb,
                                             input logic [DB-1:0] den);
        logic [DB:0] t;
        logic [DB:0] dd;
        t  = {rem, nb};
        dd = {1'b0, den};
        if (t >= dd) begin
            return {1'b1, DB'(t - dd)};
        end
        return {1'b0, t[DB-1:0]};
    endfunction

endpackage
`default_nettype wire

### hdl/eec_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_div
// Two-lane pipelined restoring divider, one quotient bit per stage. Lane x
// gives the envelope exponent, lane q the oscillation phase.
// ----------------------------------------------------------------------------
module eec_div import eec_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire t_side                 i_side,
    input  wire logic [NB-1:0]         i_num_x,
    input  wire logic [NB-1:0]         i_num_q,
    input  wire logic [DB-1:0]         i_den_x,
    input  wire logic [DB-1:0]         i_den_q,
    output t_side                      o_side,
    output logic [XB-1:0]              o_quo_x,
    output logic [ANGLE_BITS-1:0]      o_quo_q
);

    t_side           r_side [NB];
    logic [DB-1:0]   r_rem  [NB][2];
    logic [NB-1:0]   r_num  [NB][2];
    logic [QB-1:0]   r_quo  [NB][2];
    logic [DB-1:0]   w_den  [2];

    assign w_den[0] = i_den_x;
    assign w_den[1] = i_den_q;

    for (genvar j = 0; j < NB; j++) begin : g_stage
        t_side side_in;

        if (j == 0) begin : g_first
            assign side_in = i_side;
        end else begin : g_next
            assign side_in = r_side[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j] <= '0;
            end else if (i_adv) begin
                r_side[j] <= side_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DB-1:0] rem_in;
            logic [NB-1:0] num_in;
            logic [QB-1:0] quo_in;
            logic [DB:0]   step;

            if (j == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = (l == 0) ? i_num_x : i_num_q;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1][l];
                assign num_in = r_num[j-1][l];
                assign quo_in = r_quo[j-1][l];
            end

            assign step = div_step(rem_in, num_in[NB-1], w_den[l]);

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[j][l] <= step[DB-1:0];
                    r_num[j][l] <= num_in << 1;
                    r_quo[j][l] <= {quo_in[QB-2:0], step[DB]};
                end
            end
        end
    end

    assign o_side  = r_side[NB-1];
    assign o_quo_x = r_quo[NB-1][0][XB-1:0];
    assign o_quo_q = r_quo[NB-1][1][ANGLE_BITS-1:0];

endmodule
`default_nettype wire

### hdl/elastic_easing_curve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elastic_easing_curve
// Pipelined elastic easing evaluator (in, out, in-out), Q16.16 output.
//
// channel   direction  fields (low bit first)
// s_axis    in         tdata[15:0] elapsed_ticks
// m_axis    out        tdata[31:0] eased_value
// cfg       in         i_cfg_index: register, i_cfg_data: value (low bits)
//
// One item per cycle while the output is not stalled; the path runs through the
// bit-per-stage divider and the 16-stage exp2 multiplier chain.
// After reset and after each config write a sequencer derives amplitude and
// phase shift (62-step divide, then a binary asin search whose steps pass the
// mid, square, Horner, last and compare states); input is not ready meanwhile.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module elastic_easing_curve import eec_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] elapsed_ticks
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] eased_value
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MID  = 3'd2;
    localparam logic [2:0] ST_Z2   = 3'd3;
    localparam logic [2:0] ST_HORN = 3'd4;
    localparam logic [2:0] ST_LAST = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;
    localparam logic [AB-1:0] QS = AB'(1) << (AB - 2);

    typedef struct packed {
        t_side         sd;
        logic [XB-1:0] x;
        logic [30:0]   g;
        logic [30:0]   z;
        logic [30:0]   z2;
        logic [30:0]   r;
        logic          sneg;
    } t_ex;

    // config registers
    logic [1:0]         r_mode;
    logic [15:0]        r_dur;
    logic signed [31:0] r_chg;
    logic [30:0]        r_amp;
    logic [23:0]        r_per;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_dur  <= 16'd1;
            r_chg  <= '0;
            r_amp  <= '0;
            r_per  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:     r_mode <= i_cfg_data[1:0];
                REG_DURATION: r_dur  <= i_cfg_data[15:0];
                REG_CHANGE:   r_chg  <= $signed(i_cfg_data);
                REG_AMPL:     r_amp  <= i_cfg_data[30:0];
                REG_PERIOD:   r_per  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // ---------------- derived constants sequencer ----------------
    logic [2:0]      r_pc_st, n_pc_st;
    logic [5:0]      r_pc_cnt;
    logic [30:0]     r_pc_rem;
    logic [61:0]     r_pc_num;
    logic [30:0]     r_pc_rat;
    logic [AB-2:0]   r_lo, r_hi, r_mid;
    logic [30:0]     r_pc_z, r_pc_z2, r_pc_r;
    logic [1:0]      r_pc_i;
    logic [AB-1:0]   r_sft;
    logic [31:0]     r_amag;
    logic            r_aneg;
    logic [15:0]     r_dur_eff;
    logic [8:0]      r_qmul;
    logic [23:0]     r_qdiv;

    logic [31:0]     w_cm;
    logic            w_use_a;
    logic [31:0]     w_pc_t;
    logic [30:0]     w_pc_ma, w_pc_mb;
    logic [33:0]     w_pc_prod;
    logic [AB-1:0]   w_sum;
    logic [30:0]     w_coef;
    logic [15:0]     w_deff;

    assign w_cm      = r_chg[31] ? 32'(-r_chg) : 32'(r_chg);
    assign w_use_a   = (r_amp != '0) && !({1'b0, r_amp} < w_cm);
    assign w_pc_t    = {r_pc_rem, r_pc_num[61]};
    assign w_pc_ma   = (r_pc_st == ST_Z2) ? r_pc_z : r_pc_r;
    assign w_pc_mb   = (r_pc_st == ST_HORN) ? r_pc_z2 : r_pc_z;
    assign w_pc_prod = mulq30({1'b0, w_pc_ma}, {1'b0, w_pc_mb});
    assign w_sum     = AB'(r_lo) + AB'(r_hi) + AB'(1);
    assign w_coef    = SIN_C[{1'b0, r_pc_i}];
    assign w_deff    = (r_dur == '0) ? 16'd1 : r_dur;

    always_comb begin
        n_pc_st = r_pc_st;
        unique case (r_pc_st)
            ST_INIT: n_pc_st = ST_DIV;
            ST_DIV:  n_pc_st = (r_pc_cnt == 6'd61) ? ST_MID : ST_DIV;
            ST_MID:  n_pc_st = (r_lo < r_hi) ? ST_Z2 : ST_DONE;
            ST_Z2:   n_pc_st = ST_HORN;
            ST_HORN: n_pc_st = (r_pc_i == 2'd0) ? ST_LAST : ST_HORN;
            ST_LAST: n_pc_st = ST_CMP;
            ST_CMP:  n_pc_st = ST_MID;
            ST_DONE: n_pc_st = ST_DONE;
            default: n_pc_st = ST_INIT;
        endcase
        if (i_cfg_valid) begin
            n_pc_st = ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_st <= ST_INIT;
        end else begin
            r_pc_st <= n_pc_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_pc_st)
            ST_INIT: begin
                r_pc_rem  <= '0;
                r_pc_num  <= {w_cm, 30'd0};
                r_pc_cnt  <= '0;
                r_dur_eff <= w_deff;
                if (r_per != '0) begin
                    r_qmul <= 9'd256;
                    r_qdiv <= r_per;
                end else if (r_mode[1]) begin
                    r_qmul <= 9'd20;
                    r_qdiv <= 24'({w_deff, 3'd0}) + 24'(w_deff);
                end else begin
                    r_qmul <= 9'd10;
                    r_qdiv <= 24'({w_deff, 1'b0}) + 24'(w_deff);
                end
            end
            ST_DIV: begin
                if (w_pc_t >= {1'b0, r_amp}) begin
                    r_pc_rem <= 31'(w_pc_t - {1'b0, r_amp});
                    r_pc_rat <= {r_pc_rat[29:0], 1'b1};
                end else begin
                    r_pc_rem <= w_pc_t[30:0];
                    r_pc_rat <= {r_pc_rat[29:0], 1'b0};
                end
                r_pc_num <= r_pc_num << 1;
                r_pc_cnt <= r_pc_cnt + 6'd1;
                r_lo     <= '0;
                r_hi     <= QS[AB-2:0];
            end
            ST_MID: begin
                r_mid  <= w_sum[AB-1:1];
                r_pc_z <= 31'(w_sum[AB-1:1]) << (32 - AB);
                if (w_use_a) begin
                    r_sft  <= r_chg[31] ? AB'(-AB'(r_lo)) : AB'(r_lo);
                    r_amag <= {1'b0, r_amp};
                    r_aneg <= 1'b0;
                end else begin
                    r_sft  <= QS;
                    r_amag <= w_cm;
                    r_aneg <= r_chg[31];
                end
            end
            ST_Z2: begin
                r_pc_z2 <= w_pc_prod[30:0];
                r_pc_r  <= SIN_C[4];
                r_pc_i  <= 2'd3;
            end
            ST_HORN: begin
                r_pc_r <= (34'(w_coef) > w_pc_prod) ? 31'(34'(w_coef) - w_pc_prod) : '0;
                r_pc_i <= r_pc_i - 2'd1;
            end
            ST_LAST: begin
                r_pc_r <= (w_pc_prod > 34'(ONE_Q30)) ? ONE_Q30 : w_pc_prod[30:0];
            end
            ST_CMP: begin
                if (r_pc_r <= r_pc_rat) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- item pipeline ----------------
    logic w_adv;
    logic w_in_acc;

    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv && (r_pc_st == ST_DONE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // stage A: capture
    logic        r_a_valid;
    logic [15:0] r_a_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_in_acc;
        end
        if (w_adv) begin
            r_a_t <= s_axis_tdata;
        end
    end

    // stage B: signed time distance
    t_side              r_b_sd;
    logic [15:0]        r_b_wm;
    logic signed [17:0] w_b_w;
    logic [17:0]        w_b_2t;
    t_side              w_b_sd;

    assign w_b_2t = {1'b0, r_a_t, 1'b0};

    always_comb begin
        case (r_mode)
            2'd0:    w_b_w = $signed({2'b0, r_a_t}) - $signed({2'b0, r_dur_eff});
            2'd1:    w_b_w = $signed({2'b0, r_a_t});
            default: w_b_w = $signed(w_b_2t) - $signed({2'b0, r_dur_eff});
        endcase
        w_b_sd.valid  = r_a_valid;
        w_b_sd.wneg   = w_b_w[17];
        w_b_sd.second = w_b_2t >= {2'b0, r_dur_eff};
        if (r_a_t == '0) begin
            w_b_sd.kind = KIND_ZERO;
        end else if (r_a_t >= r_dur_eff) begin
            w_b_sd.kind = KIND_END;
        end else begin
            w_b_sd.kind = KIND_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_sd <= '0;
        end else if (w_adv) begin
            r_b_sd <= w_b_sd;
        end
        if (w_adv) begin
            r_b_wm <= w_b_w[17] ? 16'(-w_b_w) : w_b_w[15:0];
        end
    end

    // stage C: dividends
    t_side           r_c_sd;
    logic [NB-1:0]   r_c_numx, r_c_numq;
    logic [19:0]     w_c_x10;
    logic [24:0]     w_c_qm;

    assign w_c_x10 = 20'(r_b_wm) * 20'd10;
    assign w_c_qm  = 25'(r_b_wm) * 25'(r_qmul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_sd <= '0;
        end else if (w_adv) begin
            r_c_sd <= r_b_sd;
        end
        if (w_adv) begin
            r_c_numx <= NB'(w_c_x10) << 16;
            r_c_numq <= NB'(w_c_qm[23:0]) << AB;
        end
    end

    t_side                w_d_sd;
    logic [XB-1:0]        w_d_x;
    logic [AB-1:0]        w_d_q;

    eec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_side  (r_c_sd),
        .i_num_x (r_c_numx),
        .i_num_q (r_c_numq),
        .i_den_x (DB'(r_dur_eff)),
        .i_den_q (r_qdiv),
        .o_side  (w_d_sd),
        .o_quo_x (w_d_x),
        .o_quo_q (w_d_q)
    );

    // stage P: phase and quadrant, then 16 exp2 / sine stages
    t_ex           r_ex [17];
    t_ex           w_p;
    logic [AB-1:0] w_p_qn, w_p_th;
    logic [30:0]   w_p_z0;

    always_comb begin
        w_p_qn     = w_d_sd.wneg ? AB'(-w_d_q) : w_d_q;
        w_p_th     = w_p_qn - r_sft;
        w_p_z0     = 31'(w_p_th[AB-3:0]) << (32 - AB);
        w_p        = '0;
        w_p.sd     = w_d_sd;
        w_p.x      = w_d_x;
        w_p.g      = ONE_Q30;
        w_p.z      = w_p_th[AB-2] ? ONE_Q30 - w_p_z0 : w_p_z0;
        w_p.sneg   = w_p_th[AB-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex[0] <= '0;
        end else if (w_adv) begin
            r_ex[0] <= w_p;
        end
    end

    for (genvar i = 1; i <= 16; i++) begin : g_exp
        localparam logic [29:0] K_I = 30'(exp_k(i));
        t_ex         cur, nxt;
        logic [33:0] pg, ps;

        assign cur = r_ex[i-1];
        assign pg  = mulq30({1'b0, cur.g}, {2'b0, K_I});

        if (i == 1) begin : g_z2
            assign ps = mulq30({1'b0, cur.z}, {1'b0, cur.z});
            always_comb begin
                nxt    = cur;
                nxt.g  = cur.x[16-i] ? pg[30:0] : cur.g;
                nxt.z2 = ps[30:0];
                nxt.r  = SIN_C[4];
            end
        end else if (i <= 5) begin : g_horn
            assign ps = mulq30({1'b0, cur.r}, {1'b0, cur.z2});
            always_comb begin
                nxt   = cur;
                nxt.g = cur.x[16-i] ? pg[30:0] : cur.g;
                nxt.r = (34'(SIN_C[5-i]) > ps) ? 31'(34'(SIN_C[5-i]) - ps) : '0;
            end
        end else if (i == 6) begin : g_last
            assign ps = mulq30({1'b0, cur.r}, {1'b0, cur.z});
            always_comb begin
                nxt   = cur;
                nxt.g = cur.x[16-i] ? pg[30:0] : cur.g;
                nxt.r = (ps > 34'(ONE_Q30)) ? ONE_Q30 : ps[30:0];
            end
        end else begin : g_hold
            assign ps = '0;
            always_comb begin
                nxt   = cur;
                nxt.g = (cur.x[16-i] || (ps != '0)) ? pg[30:0] : cur.g;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex[i] <= '0;
            end else if (w_adv) begin
                r_ex[i] <= nxt;
            end
        end
    end

    // stage F: integer part of the exponent
    t_side       r_f_sd;
    logic [30:0] r_f_g, r_f_smag;
    logic        r_f_sneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_sd <= '0;
        end else if (w_adv) begin
            r_f_sd <= r_ex[16].sd;
        end
        if (w_adv) begin
            r_f_g    <= r_ex[16].g >> r_ex[16].x[XB-1:16];
            r_f_smag <= r_ex[16].r;
            r_f_sneg <= r_ex[16].sneg;
        end
    end

    // stage M1: amplitude times envelope
    t_side       r_m1_sd;
    logic [31:0] r_m1_p1;
    logic [30:0] r_m1_smag;
    logic        r_m1_tneg;
    logic [33:0] w_m1_p;

    assign w_m1_p = mulq30(r_amag, {1'b0, r_f_g});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_sd <= '0;
        end else if (w_adv) begin
            r_m1_sd <= r_f_sd;
        end
        if (w_adv) begin
            r_m1_p1   <= w_m1_p[31:0];
            r_m1_smag <= r_f_smag;
            r_m1_tneg <= r_aneg != r_f_sneg;
        end
    end

    // stage M2: times sine
    t_side       r_m2_sd;
    logic [31:0] r_m2_m;
    logic        r_m2_tneg;
    logic [63:0] w_m2_p;

    assign w_m2_p = 64'(r_m1_p1) * 64'(r_m1_smag)
                  + (r_mode[1] ? (64'd1 << 30) : (64'd1 << 29));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_sd <= '0;
        end else if (w_adv) begin
            r_m2_sd <= r_m1_sd;
        end
        if (w_adv) begin
            r_m2_m    <= r_mode[1] ? w_m2_p[62:31] : w_m2_p[61:30];
            r_m2_tneg <= r_m1_tneg;
        end
    end

    // stage O: combine and saturate
    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic signed [33:0] w_term, w_res;
    logic [31:0]        w_o_val;
    logic               w_inv;

    always_comb begin
        w_term = r_m2_tneg ? -$signed({2'b0, r_m2_m}) : $signed({2'b0, r_m2_m});
        w_inv  = (r_mode == 2'd0) || (r_mode[1] && !r_m2_sd.second);
        w_res  = w_inv ? -w_term : w_term + $signed({{2{r_chg[31]}}, r_chg});
        if (w_res > 34'sh0_7FFF_FFFF) begin
            w_o_val = 32'h7FFF_FFFF;
        end else if (w_res < -34'sh0_8000_0000) begin
            w_o_val = 32'h8000_0000;
        end else begin
            w_o_val = w_res[31:0];
        end
        case (r_m2_sd.kind)
            KIND_ZERO: w_o_val = '0;
            KIND_END:  w_o_val = r_chg;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_m2_sd.valid;
        end
        if (w_adv) begin
            r_out_data <= w_o_val;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc_st != ST_DONE) |-> !s_axis_tready)
        else $error("input taken while derived constants are being computed");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_pc_st == ST_INIT))
        else $error("config write did not restart the sequencer");

    a_sine_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex[6].sd.valid |-> (r_ex[6].r <= ONE_Q30))
        else $error("sine magnitude above one");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_m2_m) && $stable(r_m2_sd))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the elastic easing evaluator: directed table, then
// random ease samples under several curve settings, compared against a local
// fixed-point model of the Penner elastic curve.
// ----------------------------------------------------------------------------
module tb;
    import eec_pkg::*;

    localparam int LATENCY = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    elastic_easing_curve u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow configuration
    logic [1:0]  cur_mode;
    logic [15:0] cur_dur;
    logic [31:0] cur_change;
    logic [30:0] cur_ampl;
    logic [23:0] cur_period;

    logic [31:0] eased_q[$];
    int          errors;
    int          n_sent;
    int          n_got;
    bit          quiet;
    int          out_stall_n;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] fx_mul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] fx_sqrt(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] envelope(input logic [63:0] x);
        logic [63:0] g, k, n;
        g = 64'd1 << 30;
        k = fx_sqrt(64'd1 << 59);
        n = x >> 16;
        for (int i = 1; i <= 16; i++) begin
            if ((x >> (16 - i)) & 64'd1) g = fx_mul30(g, k);
            k = fx_sqrt(k << 30);
        end
        if (n > 40) n = 40;
        return g >> n;
    endfunction

    function automatic logic [63:0] quarter_sine(input logic [63:0] z);
        logic [63:0] z2, r, d;
        z2 = fx_mul30(z, z);
        r = 64'(SIN_C[4]);
        for (int i = 3; i >= 0; i--) begin
            d = fx_mul30(r, z2);
            r = (64'(SIN_C[i]) > d) ? 64'(SIN_C[i]) - d : 64'd0;
        end
        r = fx_mul30(r, z);
        return (r > (64'd1 << 30)) ? (64'd1 << 30) : r;
    endfunction

    function automatic logic [63:0] shift_steps(input logic [63:0] r);
        logic [63:0] lo, hi, mid;
        lo = 0;
        hi = 64'd1 << (ANGLE_BITS - 2);
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (quarter_sine(mid << (32 - ANGLE_BITS)) <= r) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [31:0] eased_at(input logic [15:0] tin);
        longint      t, d, c, w, term, res;
        logic [63:0] wm, x, g, q, s, th, amag, cm, smag, p1, m, z, quad, k, mask;
        bit          inout_m, second, aneg, sneg;
        int          sh;
        t = tin;
        d = (cur_dur == 0) ? 1 : cur_dur;
        c = longint'($signed(cur_change));
        mask = (64'd1 << ANGLE_BITS) - 1;
        inout_m = cur_mode >= 2;
        second = 0;
        if (t == 0) return 32'd0;
        if (t >= d) return cur_change;
        if (cur_mode == 0) w = t - d;
        else if (cur_mode == 1) w = t;
        else begin
            w = 2 * t - d;
            second = (2 * t >= d);
        end
        wm = (w < 0) ? -w : w;
        x = ((wm * 10) << 16) / d;
        g = envelope(x);
        if (cur_period != 0) q = ((wm * 256) << ANGLE_BITS) / cur_period;
        else if (!inout_m) q = ((wm * 10) << ANGLE_BITS) / (3 * d);
        else q = ((wm * 20) << ANGLE_BITS) / (9 * d);
        q = q & mask;
        if (w < 0) q = (mask + 1 - q) & mask;
        cm = (c < 0) ? -c : c;
        if (cur_ampl == 0 || 64'(cur_ampl) < cm) begin
            amag = cm;
            aneg = c < 0;
            s = 64'd1 << (ANGLE_BITS - 2);
        end else begin
            k = shift_steps((cm << 30) / cur_ampl);
            amag = cur_ampl;
            aneg = 0;
            s = (c < 0) ? ((mask + 1 - k) & mask) : k;
        end
        th = (q + mask + 1 - s) & mask;
        quad = (th >> (ANGLE_BITS - 2)) & 3;
        z = (th & ((64'd1 << (ANGLE_BITS - 2)) - 1)) << (32 - ANGLE_BITS);
        if (quad[0]) z = (64'd1 << 30) - z;
        sneg = quad[1];
        smag = quarter_sine(z);
        p1 = fx_mul30(amag, g);
        sh = inout_m ? 31 : 30;
        m = (p1 * smag + (64'd1 << (sh - 1))) >> sh;
        term = (aneg != sneg) ? -longint'(m) : longint'(m);
        if (cur_mode == 0 || (inout_m && !second)) res = -term;
        else res = term + c;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:     cur_mode   = val[1:0];
            REG_DURATION: cur_dur    = val[15:0];
            REG_CHANGE:   cur_change = val;
            REG_AMPL:     cur_ampl   = val[30:0];
            default:      cur_period = val[23:0];
        endcase
    endtask

    task automatic drain();
        int n;
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (eased_q.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic setup(input logic [1:0] md, input logic [15:0] dur, input logic [31:0] chg,
                         input logic [30:0] amp, input logic [23:0] per);
        drain();
        write_reg(REG_MODE, 32'(md));
        write_reg(REG_DURATION, 32'(dur));
        write_reg(REG_CHANGE, chg);
        write_reg(REG_AMPL, 32'(amp));
        write_reg(REG_PERIOD, 32'(per));
    endtask

    // one sample; has_exp selects the typed-in value over the model
    // tvalid stays high after the transfer so samples can follow back to back
    task automatic send(input logic [15:0] t, input bit has_exp, input logic [31:0] exp_v);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        eased_q.push_back(has_exp ? exp_v : eased_at(t));
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_got++;
                if (eased_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    if (eased_q[0] !== m_axis_tdata) begin
                        $display("%0t: eased_value mismatch, expected %h actual %h",
                                 $time, eased_q[0], m_axis_tdata);
                        errors++;
                    end
                    void'(eased_q.pop_front());
                end
            end
            if (quiet) begin
                m_axis_tready <= 1'b1;
            end else if (out_stall_n > 0) begin
                out_stall_n   <= out_stall_n - 1;
                m_axis_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 7) == 0) out_stall_n <= $urandom_range(1, 14);
                m_axis_tready <= 1'b1;
            end
        end
    end

    typedef struct {
        logic [15:0] t;
        bit          has_exp;
        logic [31:0] exp_v;
    } t_row;

    t_row dir_rows[$];

    initial begin
        logic [15:0] t;
        logic [15:0] dur;
        int          big;
        errors = 0; n_sent = 0; n_got = 0; quiet = 0; out_stall_n = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        cur_mode = 0; cur_dur = 1; cur_change = 0; cur_ampl = 0; cur_period = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: duration 1, change 0
        send(16'd0, 1, 32'd0);
        send(16'd1, 1, 32'd0);
        send(16'hFFFF, 1, 32'd0);

        setup(2'd0, 16'd100, 32'h0001_0000, 31'd0, 24'd0);
        dir_rows = '{
            '{16'd0, 1, 32'd0}, '{16'd100, 1, 32'h0001_0000},
            '{16'hFFFF, 1, 32'h0001_0000}, '{16'd1, 0, 0}, '{16'd50, 0, 0},
            '{16'd99, 0, 0}
        };
        foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].has_exp, dir_rows[i].exp_v);

        // out mode, saturating change, explicit amplitude and period
        setup(2'd1, 16'hFFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFFFFFF);
        send(16'd1, 0, 0); send(16'h8000, 0, 0); send(16'hFFFE, 0, 0);
        send(16'hFFFF, 1, 32'h7FFF_FFFF);
        setup(2'd2, 16'd9, 32'h8000_0000, 31'd0, 24'd0);
        for (int i = 0; i <= 9; i++) send(16'(i), 0, 0);
        // unused mode code, zero duration
        setup(2'd3, 16'd0, 32'hFFF0_0000, 31'h0010_0000, 24'd300);
        send(16'd0, 1, 32'd0); send(16'd1, 1, 32'hFFF0_0000);
        setup(2'd3, 16'd40, 32'hFFF0_0000, 31'h0020_0000, 24'd300);
        send(16'd13, 0, 0); send(16'd27, 0, 0);

        for (int ph = 0; ph < 18; ph++) begin
            big = (ph % 6 == 5);
            dur = big ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 400));
            if (ph == 9) dur = 16'hFFFF;
            case ($urandom_range(0, 3))
                0: setup(2'($urandom_range(0, 3)), dur, $urandom, 31'd0, 24'd0);
                1: setup(2'($urandom_range(0, 3)), dur, 32'($urandom_range(0, 2000000)) ^
                         {32{1'($urandom)}}, 31'($urandom), 24'($urandom));
                2: setup(2'($urandom_range(0, 3)), dur, $urandom, $urandom_range(0, 1) ?
                         31'h7FFF_FFFF : 31'($urandom_range(0, 100000)), 24'($urandom));
                default: setup(2'($urandom_range(0, 3)), dur, $urandom, 31'($urandom),
                               24'($urandom_range(1, 4000)));
            endcase
            if (ph == 17) quiet = 1;
            for (int n = 0; n < 100; n++) begin
                case ($urandom_range(0, 9))
                    0: t = 16'($urandom);
                    1: t = 16'(dur - 1);
                    default: t = 16'($urandom_range(0, dur));
                endcase
                send(t, 0, 0);
            end
            if (ph == 3) begin
                // hold the sender until every result is back
                s_axis_tvalid <= 1'b0;
                while (eased_q.size() != 0) @(posedge i_clk);
                send(16'($urandom_range(0, dur)), 0, 0);
            end
        end

        drain();
        $display("Covered %0d samples, %0d results, all ease modes incl. unused code,",
                 n_sent, n_got);
        $display("default and explicit amplitude/period, extremes and saturation.");
        if (errors == 0 && eased_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
